// ----- sv/buzz_pkg.sv -----
// ----------------------------------------------------------------------------
// buzz_pkg
// Shared types and constants for the buzzer tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package buzz_pkg;

    // Field widths of the request and of the internal counters.
    localparam int FREQ_W   = 16;
    localparam int DUR_W    = 24;
    localparam int ELAPS_W  = 16;
    localparam int RELOAD_W = 16;
    localparam int DVSR_W   = FREQ_W + 1;

    // Tone requests no longer than this are dropped while a tone is sounding.
    localparam logic [DUR_W-1:0] SHORT_BEEP_MS = 24'd30;

    // Reset value of the half-period reload.
    localparam logic [RELOAD_W-1:0] RELOAD_RESET = 16'd999;

    // Smallest half period in ticks.
    localparam logic [31:0] MIN_HALF = 32'd2;

    // Largest half period that still fits the reload.
    localparam logic [31:0] MAX_HALF = 32'd65536;

    // Action codes of a request.
    typedef enum logic [1:0] {
        ACT_TONE    = 2'd0,
        ACT_ELAPSED = 2'd1,
        ACT_TICK    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EXEC   = 2'd1,
        ST_DIV    = 2'd2,
        ST_COMMIT = 2'd3
    } t_state;

endpackage

`default_nettype wire

// ----- sv/buzzer_tone_generator.sv -----
// ----------------------------------------------------------------------------
// buzzer_tone_generator
// Square-wave buzzer driver with a tick divider, a millisecond countdown and
// a serial restoring divider that turns a tone frequency into a half period.
// ----------------------------------------------------------------------------
// Flow: an accepted request passes from IDLE through EXEC and COMMIT into the
// output register; a tone start runs the serial divider in DIV between EXEC
// and COMMIT, DW = clog2(TICK_RATE_HZ + 1) being the width of the divider's
// bit-per-cycle loop (20 at the default tick rate). A new request is taken
// only in IDLE, once the last has committed; a held result stalls COMMIT.
// Reset (synchronous, active low) enables the block, stops the tone and loads 999.
`default_nettype none

module buzzer_tone_generator #(
    parameter int TICK_RATE_HZ = 1000000
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Request channel.
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [1:0]                  i_action,
    input  wire logic [buzz_pkg::FREQ_W-1:0] i_tone_freq,
    input  wire logic [buzz_pkg::DUR_W-1:0]  i_tone_duration_ms,
    input  wire logic [buzz_pkg::ELAPS_W-1:0] i_elapsed_ms,
    // Result channel.
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_pin_level,
    output logic                             o_sounding,
    // Configuration channel.
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic                        i_cfg_enable
);

    // Dividend width and iteration counter width of the serial divider.
    localparam int DW = $clog2(TICK_RATE_HZ + 1);
    localparam int CW = (DW > 1) ? $clog2(DW) : 1;
    localparam logic [DW-1:0] DIVIDEND = DW'(TICK_RATE_HZ);
    localparam logic [CW-1:0] LAST_STEP = CW'(DW - 1);

    // Sequencer and captured request.
    buzz_pkg::t_state                  r_state,   n_state;
    buzz_pkg::t_action                 r_action,  n_action;
    logic [buzz_pkg::FREQ_W-1:0]       r_freq,    n_freq;
    logic [buzz_pkg::DUR_W-1:0]        r_dur,     n_dur;
    logic [buzz_pkg::ELAPS_W-1:0]      r_elapsed, n_elapsed;

    // Tone state.
    logic                              r_enable,  n_enable;
    logic                              r_level,   n_level;
    logic                              r_active,  n_active;
    logic                              r_running, n_running;
    logic [buzz_pkg::DUR_W-1:0]        r_remain,  n_remain;
    logic [buzz_pkg::RELOAD_W-1:0]     r_reload,  n_reload;
    logic [buzz_pkg::RELOAD_W-1:0]     r_count,   n_count;

    // Serial divider.
    logic [buzz_pkg::DVSR_W-1:0]       r_rem,     n_rem;
    logic [DW-1:0]                     r_dvd,     n_dvd;
    logic [DW-1:0]                     r_quo,     n_quo;
    logic [CW-1:0]                     r_step,    n_step;

    // Output register.
    logic                              r_out_valid, n_out_valid;
    logic                              r_out_level, n_out_level;
    logic                              r_out_sound, n_out_sound;

    // Decode helpers.
    logic                              tone_short;
    logic                              tone_start;
    logic [buzz_pkg::DVSR_W:0]         trial;
    logic [buzz_pkg::DVSR_W:0]         divisor;
    logic                              fits;
    logic [31:0]                       half;
    logic [buzz_pkg::RELOAD_W-1:0]     reload_sat;
    logic [buzz_pkg::ELAPS_W-1:0]      elapsed_dummy;

    assign o_ready     = (r_state == buzz_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_pin_level = r_out_level;
    assign o_sounding  = r_out_sound;
    assign elapsed_dummy = r_elapsed;

    // A tone request that restarts the divider with a new half period.
    assign tone_short = r_active && (r_dur <= buzz_pkg::SHORT_BEEP_MS);
    assign tone_start = (r_action == buzz_pkg::ACT_TONE) && r_enable
                        && (r_freq != '0) && !tone_short;

    // One restoring step: bring down the next dividend bit and try to subtract.
    assign trial   = {r_rem, r_dvd[DW-1]};
    assign divisor = {1'b0, r_freq, 1'b0};
    assign fits    = (trial >= divisor);

    // Half period clamped to the reload range, then minus one.
    always_comb begin
        half = 32'(r_quo);
        if (half < buzz_pkg::MIN_HALF) begin
            half = buzz_pkg::MIN_HALF;
        end
        if (half > buzz_pkg::MAX_HALF) begin
            half = buzz_pkg::MAX_HALF;
        end
        reload_sat = buzz_pkg::RELOAD_W'(half - 32'd1);
    end

    // Next state and datapath.
    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_freq      = r_freq;
        n_dur       = r_dur;
        n_elapsed   = r_elapsed;
        n_enable    = r_enable;
        n_level     = r_level;
        n_active    = r_active;
        n_running   = r_running;
        n_remain    = r_remain;
        n_reload    = r_reload;
        n_count     = r_count;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_quo       = r_quo;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out_level = r_out_level;
        n_out_sound = r_out_sound;

        // The downstream side takes the waiting result.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            buzz_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_action  = buzz_pkg::t_action'(i_action);
                    n_freq    = i_tone_freq;
                    n_dur     = i_tone_duration_ms;
                    n_elapsed = i_elapsed_ms;
                    n_state   = buzz_pkg::ST_EXEC;
                end
            end
            buzz_pkg::ST_EXEC: begin
                if (tone_start) begin
                    n_rem   = '0;
                    n_dvd   = DIVIDEND;
                    n_quo   = '0;
                    n_step  = LAST_STEP;
                    n_state = buzz_pkg::ST_DIV;
                end else begin
                    n_state = buzz_pkg::ST_COMMIT;
                end
            end
            buzz_pkg::ST_DIV: begin
                n_rem = fits ? buzz_pkg::DVSR_W'(trial - divisor)
                             : buzz_pkg::DVSR_W'(trial);
                n_quo = {r_quo[DW-2:0], fits};
                n_dvd = {r_dvd[DW-2:0], 1'b0};
                n_step = r_step - CW'(1);
                if (r_step == '0) begin
                    n_state = buzz_pkg::ST_COMMIT;
                end
            end
            buzz_pkg::ST_COMMIT: begin
                // Update the tone state once the output register has room.
                if (!r_out_valid || i_ready) begin
                    case (r_action)
                        buzz_pkg::ACT_TONE: begin
                            if (r_enable && (r_freq == '0)) begin
                                n_running = 1'b0;
                                n_level   = 1'b0;
                                n_active  = 1'b0;
                                n_remain  = '0;
                            end else if (tone_start) begin
                                n_reload  = reload_sat;
                                n_count   = '0;
                                n_running = 1'b1;
                                n_remain  = r_dur;
                                n_active  = (r_dur != '0);
                            end
                        end
                        buzz_pkg::ACT_ELAPSED: begin
                            if (r_active) begin
                                if (r_remain <= buzz_pkg::DUR_W'(elapsed_dummy)) begin
                                    n_running = 1'b0;
                                    n_level   = 1'b0;
                                    n_active  = 1'b0;
                                    n_remain  = '0;
                                end else begin
                                    n_remain = r_remain
                                               - buzz_pkg::DUR_W'(elapsed_dummy);
                                end
                            end
                        end
                        buzz_pkg::ACT_TICK: begin
                            if (r_running) begin
                                if (r_count >= r_reload) begin
                                    n_count = '0;
                                    n_level = r_active ? !r_level : 1'b0;
                                end else begin
                                    n_count = r_count + buzz_pkg::RELOAD_W'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_valid = 1'b1;
                    n_out_level = n_level;
                    n_out_sound = n_active;
                    n_state     = buzz_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = buzz_pkg::ST_IDLE;
            end
        endcase

        // Enable write; clearing it stops the tone at once.
        if (i_cfg_valid) begin
            n_enable = i_cfg_enable;
            if (!i_cfg_enable) begin
                n_running = 1'b0;
                n_level   = 1'b0;
                n_active  = 1'b0;
                n_remain  = '0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= buzz_pkg::ST_IDLE;
            r_enable    <= 1'b1;
            r_level     <= 1'b0;
            r_active    <= 1'b0;
            r_running   <= 1'b0;
            r_remain    <= '0;
            r_reload    <= buzz_pkg::RELOAD_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_enable    <= n_enable;
            r_level     <= n_level;
            r_active    <= n_active;
            r_running   <= n_running;
            r_remain    <= n_remain;
            r_reload    <= n_reload;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_freq      <= n_freq;
        r_dur       <= n_dur;
        r_elapsed   <= n_elapsed;
        r_rem       <= n_rem;
        r_dvd       <= n_dvd;
        r_quo       <= n_quo;
        r_step      <= n_step;
        r_out_level <= n_out_level;
        r_out_sound <= n_out_sound;
    end

    // A tone is sounding exactly while time remains on the countdown.
    a_active_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == (r_remain != '0))
        else $error("active flag and remaining time disagree");

    // With the divider stopped the pin is low.
    a_stopped_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> !r_level)
        else $error("pin high while divider stopped");

    // A disabled block stays silent.
    a_disabled_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_enable |-> (!r_running && !r_active))
        else $error("tone running while disabled");

endmodule

`default_nettype wire

// ----- dv/buzzer_tone_generator_tb.sv -----
// ----------------------------------------------------------------------------
// buzzer_tone_generator_tb
// Self-checking bench for the buzzer tone generator. A queue of pending
// requests and enable writes feeds a clocked driver with bursty timing. The
// receiver stalls in changing patterns. A per-request predictor of the tone
// state turns each accepted request into an expected pin level and sounding
// flag, and a monitor compares every result against the oldest of those.
// ----------------------------------------------------------------------------
`default_nettype none

module buzzer_tone_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_HZ     = 1000000;
    localparam int SETTLE_CYC  = 40;
    localparam int CYCLE_LIMIT = 600000;

    // Kinds of entries in the pending queue.
    typedef enum logic [1:0] {
        SLOT_REQ   = 2'd0,
        SLOT_CFG   = 2'd1,
        SLOT_DRAIN = 2'd2
    } t_slot_kind;

    typedef struct {
        t_slot_kind                      kind;
        buzz_pkg::t_action               action;
        logic [buzz_pkg::FREQ_W-1:0]     freq;
        logic [buzz_pkg::DUR_W-1:0]      dur;
        logic [buzz_pkg::ELAPS_W-1:0]    el;
        logic                            cfg_en;
    } t_slot;

    typedef struct {
        logic pin;
        logic snd;
    } t_tone_out;

    // DUT connections; the inputs are known from time zero.
    logic                           i_clk              = 1'b0;
    logic                           i_rst_n            = 1'b0;
    logic                           i_valid            = 1'b0;
    logic                           o_ready;
    logic [1:0]                     i_action           = buzz_pkg::ACT_NONE;
    logic [buzz_pkg::FREQ_W-1:0]    i_tone_freq        = '0;
    logic [buzz_pkg::DUR_W-1:0]     i_tone_duration_ms = '0;
    logic [buzz_pkg::ELAPS_W-1:0]   i_elapsed_ms       = '0;
    logic                           o_valid;
    logic                           i_ready            = 1'b0;
    logic                           o_pin_level;
    logic                           o_sounding;
    logic                           i_cfg_valid        = 1'b0;
    logic                           o_cfg_ready;
    logic                           i_cfg_enable       = 1'b1;

    // Bench bookkeeping.
    t_slot      pend_q[$];
    t_tone_out  tone_exp[$];
    int         mismatches = 0;
    int         n_items    = 0;
    int         cycles     = 0;
    logic       in_fired   = 1'b0;
    logic       cfg_fired  = 1'b0;
    int         gap_left   = 0;
    int         burst_left = 4;
    int         quiet_cyc  = 0;
    int         rdy_mode   = 0;
    int         rdy_left   = 0;

    // Predicted block state.
    logic                           en_q     = 1'b1;
    logic                           lvl_q    = 1'b0;
    logic                           act_q    = 1'b0;
    logic                           run_q    = 1'b0;
    logic [buzz_pkg::DUR_W-1:0]     left_ms  = '0;
    logic [buzz_pkg::RELOAD_W-1:0]  reload_q = buzz_pkg::RELOAD_RESET;
    logic [buzz_pkg::RELOAD_W-1:0]  count_q  = '0;

    buzzer_tone_generator #(
        .TICK_RATE_HZ(TICK_HZ)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_action           (i_action),
        .i_tone_freq        (i_tone_freq),
        .i_tone_duration_ms (i_tone_duration_ms),
        .i_elapsed_ms       (i_elapsed_ms),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_pin_level        (o_pin_level),
        .o_sounding         (o_sounding),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_enable       (i_cfg_enable)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Stopping clears the run, level and active flags and the remaining time.
    task automatic halt_tone();
        run_q   = 1'b0;
        lvl_q   = 1'b0;
        act_q   = 1'b0;
        left_ms = '0;
    endtask

    // Half period in ticks, clamped low, minus one, saturated to the reload.
    function automatic logic [buzz_pkg::RELOAD_W-1:0] tone_reload(
        logic [buzz_pkg::FREQ_W-1:0] f);
        longint unsigned h;
        h = longint'(TICK_HZ) / (2 * longint'(f));
        if (h < buzz_pkg::MIN_HALF)
            h = buzz_pkg::MIN_HALF;
        if (h > buzz_pkg::MAX_HALF)
            h = buzz_pkg::MAX_HALF;
        return buzz_pkg::RELOAD_W'(h - 1);
    endfunction

    // Advance the predicted state by one request and return the result.
    task automatic tone_step(input t_slot s, output t_tone_out r);
        case (s.action)
            buzz_pkg::ACT_TONE: begin
                if (en_q) begin
                    if (s.freq == 0) begin
                        halt_tone();
                    end else if (!(act_q && s.dur <= buzz_pkg::SHORT_BEEP_MS)) begin
                        reload_q = tone_reload(s.freq);
                        count_q  = '0;
                        run_q    = 1'b1;
                        left_ms  = s.dur;
                        act_q    = (s.dur != 0);
                    end
                end
            end
            buzz_pkg::ACT_ELAPSED: begin
                if (act_q) begin
                    if (left_ms <= s.el)
                        halt_tone();
                    else
                        left_ms = left_ms - s.el;
                end
            end
            buzz_pkg::ACT_TICK: begin
                if (run_q) begin
                    if (count_q >= reload_q) begin
                        count_q = '0;
                        lvl_q   = act_q ? ~lvl_q : 1'b0;
                    end else begin
                        count_q = count_q + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.pin = lvl_q;
        r.snd = act_q;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic push_req(buzz_pkg::t_action a, int f, int d, int e);
        t_slot s;
        s.kind   = SLOT_REQ;
        s.action = a;
        s.freq   = buzz_pkg::FREQ_W'(f);
        s.dur    = buzz_pkg::DUR_W'(d);
        s.el     = buzz_pkg::ELAPS_W'(e);
        s.cfg_en = 1'b0;
        pend_q.push_back(s);
        n_items++;
    endtask

    task automatic push_ctl(t_slot_kind k, logic en);
        t_slot s;
        s.kind   = k;
        s.action = buzz_pkg::ACT_NONE;
        s.freq   = '0;
        s.dur    = '0;
        s.el     = '0;
        s.cfg_en = en;
        pend_q.push_back(s);
    endtask

    // Mostly high tones so the divider wraps often; some slow and saturated.
    function automatic int pick_freq();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return $urandom_range(20000, 65535);
        else if (sel < 9)
            return $urandom_range(1, 19999);
        else
            return $urandom_range(0, 65535);
    endfunction

    // Silent, short, ordinary and huge durations.
    function automatic int pick_dur();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 5)
            return 0;
        else if (sel < 10)
            return $urandom_range(1, 40);
        else if (sel < 18)
            return $urandom_range(41, 400);
        else
            return $urandom & 32'h00FF_FFFF;
    endfunction

    // A tone request followed by a run of ticks and elapsed reports.
    task automatic push_tone_run();
        int n;
        int sel;
        push_req(buzz_pkg::ACT_TONE, pick_freq(), pick_dur(), $urandom_range(0, 65535));
        n = $urandom_range(8, 40);
        repeat (n) begin
            sel = $urandom_range(0, 19);
            if (sel < 15)
                push_req(buzz_pkg::ACT_TICK, $urandom_range(0, 65535),
                         $urandom & 32'hFF_FFFF, $urandom_range(0, 65535));
            else if (sel < 18)
                push_req(buzz_pkg::ACT_ELAPSED, $urandom_range(0, 65535),
                         $urandom & 32'hFF_FFFF,
                         ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 40));
            else
                push_req(buzz_pkg::ACT_TONE, pick_freq(), $urandom_range(0, 45),
                         $urandom_range(0, 65535));
        end
    endtask

    // Unstructured requests of any action.
    task automatic push_noise();
        repeat ($urandom_range(1, 5))
            push_req(buzz_pkg::t_action'($urandom_range(0, 3)), $urandom_range(0, 65535),
                     $urandom & 32'hFF_FFFF, $urandom_range(0, 65535));
    endtask

    task automatic push_random(int count);
        int target;
        target = n_items + count;
        while (n_items < target) begin
            if ($urandom_range(0, 9) < 7)
                push_tone_run();
            else
                push_noise();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        // Enable write first, once reset is released and the block has settled.
        push_ctl(SLOT_CFG, 1'b1);

        // Directed corners.
        push_req(buzz_pkg::ACT_TICK, 0, 0, 0);                   // tick while stopped
        push_req(buzz_pkg::ACT_ELAPSED, 0, 0, 65535);            // elapsed while idle
        push_req(buzz_pkg::ACT_NONE, 65535, 24'hFF_FFFF, 65535); // unused action
        push_req(buzz_pkg::ACT_TONE, 65535, 0, 0);               // divider runs, pin low
        repeat (7) push_req(buzz_pkg::ACT_TICK, 0, 0, 0);
        push_req(buzz_pkg::ACT_TONE, 65535, 24'hFF_FFFF, 0);     // longest timed tone
        repeat (7) push_req(buzz_pkg::ACT_TICK, 0, 0, 0);
        push_req(buzz_pkg::ACT_TONE, 1, 30, 0);                  // short beep: dropped
        push_req(buzz_pkg::ACT_TONE, 1, 31, 0);                  // reload saturates
        push_req(buzz_pkg::ACT_ELAPSED, 0, 0, 30);
        push_req(buzz_pkg::ACT_ELAPSED, 0, 0, 1);                // expires exactly
        push_req(buzz_pkg::ACT_TONE, 50000, 40, 0);
        push_req(buzz_pkg::ACT_TONE, 0, 5, 0);                   // zero frequency stops

        // Random traffic with the enable switched through both values.
        push_random(250);
        push_ctl(SLOT_DRAIN, 1'b0);
        push_random(250);
        push_ctl(SLOT_CFG, 1'b0);
        push_random(40);
        push_ctl(SLOT_CFG, 1'b1);
        push_random(250);
        push_tone_run();
        push_ctl(SLOT_CFG, 1'b0);
        push_ctl(SLOT_CFG, 1'b1);
        push_random(250);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || i_valid || i_cfg_valid || tone_exp.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: requests in bursts, enable writes only when the block is idle.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_req
        logic  v_nxt;
        logic  c_nxt;
        t_slot s;
        v_nxt = i_valid && !in_fired;
        c_nxt = i_cfg_valid && !cfg_fired;
        if (i_rst_n && !v_nxt && !c_nxt && pend_q.size() != 0) begin
            if (pend_q[0].kind == SLOT_REQ) begin
                quiet_cyc = 0;
                if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    s = pend_q.pop_front();
                    i_action           <= s.action;
                    i_tone_freq        <= s.freq;
                    i_tone_duration_ms <= s.dur;
                    i_elapsed_ms       <= s.el;
                    v_nxt = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0
                                                                 : $urandom_range(1, 12);
                    end
                end
            end else begin
                // Hold off until every result is back and the block has settled.
                quiet_cyc = (tone_exp.size() == 0) ? quiet_cyc + 1 : 0;
                if (quiet_cyc >= SETTLE_CYC) begin
                    quiet_cyc = 0;
                    s = pend_q.pop_front();
                    if (s.kind == SLOT_CFG) begin
                        i_cfg_enable <= s.cfg_en;
                        c_nxt = 1'b1;
                    end
                end
            end
        end
        i_valid     <= v_nxt;
        i_cfg_valid <= c_nxt;
    end

    // Receiver back-pressure, switching between patterns.
    always @(negedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = $urandom_range(20, 300);
        end
        rdy_left--;
        case (rdy_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= ($urandom_range(0, 3) != 0);
            2:       i_ready <= ($urandom_range(0, 7) == 0);
            default: i_ready <= ((cycles % 5) < 2);
        endcase
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on acceptance, check each result.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_slot     s;
        t_tone_out r;
        if (!i_rst_n) begin
            in_fired  <= 1'b0;
            cfg_fired <= 1'b0;
        end else begin
            in_fired  <= i_valid && o_ready;
            cfg_fired <= i_cfg_valid && o_cfg_ready;

            // Results are checked against the oldest outstanding request.
            if (o_valid && i_ready) begin
                if (tone_exp.size() == 0) begin
                    $error("unexpected result: pin_level=%0b sounding=%0b",
                           o_pin_level, o_sounding);
                    mismatches++;
                end else begin
                    r = tone_exp.pop_front();
                    if (o_pin_level !== r.pin) begin
                        $error("pin_level: expected %0b, actual %0b", r.pin, o_pin_level);
                        mismatches++;
                    end
                    if (o_sounding !== r.snd) begin
                        $error("sounding: expected %0b, actual %0b", r.snd, o_sounding);
                        mismatches++;
                    end
                end
            end

            // An enable write of 0 stops the tone at once.
            if (i_cfg_valid && o_cfg_ready) begin
                en_q = i_cfg_enable;
                if (!en_q)
                    halt_tone();
            end

            if (i_valid && o_ready) begin
                s.kind   = SLOT_REQ;
                s.action = buzz_pkg::t_action'(i_action);
                s.freq   = i_tone_freq;
                s.dur    = i_tone_duration_ms;
                s.el     = i_elapsed_ms;
                s.cfg_en = 1'b0;
                tone_step(s, r);
                tone_exp.push_back(r);
            end
        end
    end

endmodule

`default_nettype wire
